>>> src/ism_pkg.sv
package ism_pkg;

  localparam int CounterBits = 32;
  localparam int WinLen      = 18;
  localparam int WinBits     = WinLen * 8;
  localparam int SqlCount    = 32;
  localparam int XssCount    = 24;

  localparam logic [1:0] ClassNone = 2'd0;
  localparam logic [1:0] ClassSql  = 2'd1;
  localparam logic [1:0] ClassXss  = 2'd2;

  localparam logic [1:0] LevelNone = 2'd0;
  localparam logic [1:0] LevelLow  = 2'd1;
  localparam logic [1:0] LevelMed  = 2'd2;
  localparam logic [1:0] LevelHigh = 2'd3;

  typedef logic [WinBits-1:0] sig_t;

  // Literals are right aligned: the last character sits in the low byte,
  // which lines up with the newest byte of the window.
  localparam sig_t SqlSigs [SqlCount] = '{
    "union select", "union all select", "; drop ", "; delete ",
    "; truncate ", "; update ", "; insert ", "into outfile",
    "into dumpfile", {"load_", "file("},
    "or 1=1", "or '1'='1", "' or '", "or true--", "or true;", "' or true",
    "sleep(", "benchmark(", "waitfor delay", "'; --", "' --", "'/*",
    "*/or/*", "char(0x", "exec(", "execute(", {"xp_", "cmdshell"},
    {"information", "_schema"},
    "' or 1", "'a'='a", "1' or '1", "admin'--"
  };

  localparam sig_t XssSigs [XssCount] = '{
    "<script", "javascript:", "eval(", "document.cookie", "document.write(",
    "document.location", "window.location", ".innerhtml",
    "onerror=", "onload=", "onclick=", "onmouseover=", "onfocus=",
    "onsubmit=", "<iframe", "<object", "<embed", "<svg onload", "<img src=",
    "<body onload",
    "alert(", "prompt(", "confirm(", "<marquee"
  };

  typedef struct packed {
    logic [SqlCount-1:0] sql;
    logic [XssCount-1:0] xss;
  } hits_t;

  // Compare only the bytes the signature actually has.
  function automatic logic sig_match(input sig_t win, input sig_t sig);
    sig_t mask;
    for (int b = 0; b < WinLen; b++) begin
      mask[b*8 +: 8] = (sig[b*8 +: 8] != 8'd0) ? 8'hff : 8'h00;
    end
    return ((win ^ sig) & mask) == '0;
  endfunction

  function automatic logic [1:0] sql_level(input logic [4:0] idx);
    return (idx < 5'd10) ? LevelHigh : (idx < 5'd28) ? LevelMed : LevelLow;
  endfunction

  function automatic logic [1:0] xss_level(input logic [4:0] idx);
    return (idx < 5'd8) ? LevelHigh : (idx < 5'd20) ? LevelMed : LevelLow;
  endfunction

endpackage

>>> src/ism_front.sv
module ism_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          push,
  output ism_pkg::hits_t push_hits,
  input  logic          q_full
);
  import ism_pkg::*;

  logic [WinBits-9:0] window;
  hits_t              hits;
  logic [7:0]         folded;
  sig_t               win;
  hits_t              hits_now;
  logic               accept;

  // Fold A-Z to lower case.
  assign folded = (in_byte >= 8'h41 && in_byte <= 8'h5a) ? (in_byte + 8'h20) : in_byte;
  assign win    = {window, folded};

  always_comb begin
    hits_now = hits;
    for (int i = 0; i < SqlCount; i++) begin
      if (sig_match(win, SqlSigs[i])) hits_now.sql[i] = 1'b1;
    end
    for (int i = 0; i < XssCount; i++) begin
      if (sig_match(win, XssSigs[i])) hits_now.xss[i] = 1'b1;
    end
  end

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign push      = accept && in_last;
  assign push_hits = hits_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      hits   <= '0;
    end else if (accept) begin
      if (in_last) begin
        window <= '0;
        hits   <= '0;
      end else begin
        window <= win[WinBits-9:0];
        hits   <= hits_now;
      end
    end
  end

endmodule

>>> src/ism_queue.sv
module ism_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ism_pkg::hits_t push_hits,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output ism_pkg::hits_t pop_hits
);
  import ism_pkg::*;

  hits_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_hits = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_hits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");
`endif

endmodule

>>> src/ism_back.sv
module ism_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  ism_pkg::hits_t q_hits,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_class,
  output logic [1:0]     out_level,
  output logic [4:0]     out_index,
  output logic [31:0]    out_sql,
  output logic [31:0]    out_xss,
  output logic [31:0]    out_total
);
  import ism_pkg::*;

  logic [CounterBits-1:0] sql_cnt, xss_cnt, total_cnt;
  logic [CounterBits-1:0] sql_cnt_next, xss_cnt_next, total_cnt_next;
  logic [CounterBits:0]   total_sum;
  logic                   s_hit, x_hit;
  logic [4:0]             s_idx, x_idx;
  logic [1:0]             s_lvl, x_lvl;
  logic [1:0]             class_next, level_next;
  logic [4:0]             index_next;
  logic [CounterBits+31:0] sql_ext, xss_ext, total_ext;

  assign pop = !q_empty && (!out_valid || out_ready);

  // First hit in table order wins within a class.
  always_comb begin
    s_idx = '0;
    x_idx = '0;
    for (int i = SqlCount - 1; i >= 0; i--) begin
      if (q_hits.sql[i]) s_idx = 5'(i);
    end
    for (int i = XssCount - 1; i >= 0; i--) begin
      if (q_hits.xss[i]) x_idx = 5'(i);
    end
  end

  assign s_hit = |q_hits.sql;
  assign x_hit = |q_hits.xss;
  assign s_lvl = s_hit ? sql_level(s_idx) : LevelNone;
  assign x_lvl = x_hit ? xss_level(x_idx) : LevelNone;

  always_comb begin
    if (s_hit && s_lvl >= x_lvl) begin
      class_next = ClassSql;
      level_next = s_lvl;
      index_next = s_idx;
    end else if (x_hit) begin
      class_next = ClassXss;
      level_next = x_lvl;
      index_next = x_idx;
    end else begin
      class_next = ClassNone;
      level_next = LevelNone;
      index_next = '0;
    end
  end

  // Saturate every counter at all ones.
  assign sql_cnt_next = (s_hit && sql_cnt != '1) ? sql_cnt + 1'b1 : sql_cnt;
  assign xss_cnt_next = (x_hit && xss_cnt != '1) ? xss_cnt + 1'b1 : xss_cnt;
  assign total_sum    = {1'b0, total_cnt} + (CounterBits+1)'({1'b0, s_hit} + {1'b0, x_hit});
  assign total_cnt_next = total_sum[CounterBits] ? '1 : total_sum[CounterBits-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sql_cnt   <= '0;
      xss_cnt   <= '0;
      total_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        sql_cnt   <= sql_cnt_next;
        xss_cnt   <= xss_cnt_next;
        total_cnt <= total_cnt_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_class <= class_next;
      out_level <= level_next;
      out_index <= index_next;
    end
  end

  assign sql_ext   = {32'd0, sql_cnt};
  assign xss_ext   = {32'd0, xss_cnt};
  assign total_ext = {32'd0, total_cnt};
  assign out_sql   = sql_ext[31:0];
  assign out_xss   = xss_ext[31:0];
  assign out_total = total_ext[31:0];

`ifndef SYNTH
  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_class == ClassNone |-> out_level == LevelNone && out_index == 5'd0)
    else $error("no-hit result carries level or index");
  a_hit_has_level: assert property (@(posedge clk) disable iff (rst)
      out_valid && (out_class == ClassSql || out_class == ClassXss) |-> out_level != LevelNone)
    else $error("hit result without level");
  a_total_bounds: assert property (@(posedge clk) disable iff (rst)
      total_cnt >= sql_cnt && total_cnt >= xss_cnt)
    else $error("total counter below a class counter");
`endif

endmodule

>>> src/injection_signature_matcher_unit.sv
// Channel   Dir  Group                     Payload
// -------   ---  ------------------------  ------------------------------------------
// query     in   s_tvalid/s_tready/s_tdata  tdata[7:0] text_byte, tlast last_byte
// verdict   out  m_tvalid/m_tready/m_tdata  tdata: class, level, index, three counters
//
// One query byte is taken per cycle while the queue is not full; the signature
// compare runs in the cycle the byte arrives. A last byte pushes the hit vector
// into a two-entry queue, from which the back end pops it and registers the verdict.
// Reset (rst, synchronous) clears the window, hit bits, queue and all counters.
// The input stalls only while the queue holds two hit vectors.
module injection_signature_matcher_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] text_byte
  input  logic         s_tlast,   // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata    // [1:0] threat_class, [3:2] threat_level,
                                  // [8:4] signature_index, [40:9] sql_queries_flagged,
                                  // [72:41] xss_queries_flagged, [104:73] threats_total,
                                  // [111:105] zero
);
  import ism_pkg::*;

  logic        push, q_full, q_empty, pop;
  hits_t       push_hits, pop_hits;
  logic [1:0]  t_class, t_level;
  logic [4:0]  t_index;
  logic [31:0] t_sql, t_xss, t_total;

  // Fold, shift and match each byte; hand finished queries to the queue.
  ism_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .push      (push),
    .push_hits (push_hits),
    .q_full    (q_full)
  );

  // Hold per-query hit vectors so the front keeps streaming while output stalls.
  ism_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_hits (push_hits),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_hits  (pop_hits)
  );

  // Pick the winner, advance the counters, register the verdict request.
  ism_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_hits    (pop_hits),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_class (t_class),
    .out_level (t_level),
    .out_index (t_index),
    .out_sql   (t_sql),
    .out_xss   (t_xss),
    .out_total (t_total)
  );

  assign m_tdata = {7'd0, t_total, t_xss, t_sql, t_index, t_level, t_class};

endmodule

>>> tb/sv/tb_injection_signature_matcher_unit.sv
`timescale 1ns / 1ps

module tb_injection_signature_matcher_unit;
  import ism_pkg::*;

  localparam int RandomBytes   = 1050;
  localparam int IdlePercent   = 37;
  localparam int CalmFrom      = 300;   // no idling on either side in this byte range
  localparam int CalmTo        = 500;
  localparam int HoldAt        = 700;   // receiver starts its long hold-off here
  localparam int HoldCycles    = 250;
  localparam int StallLimit    = 2000;  // cycles with no request moving on either side
  localparam int ReportLimit   = 10;
  localparam int SettleCycles  = 8;     // settle time after the last verdict is drained
  localparam int TypedProbes   = 2;     // probes whose verdict is taken as typed

  // One verdict, field by field.
  typedef struct packed {
    logic [1:0]  threat_class;
    logic [1:0]  threat_level;
    logic [4:0]  signature_index;
    logic [31:0] sql_queries_flagged;
    logic [31:0] xss_queries_flagged;
    logic [31:0] threats_total;
  } verdict_t;

  // Directed query: the body is sent from its highest nonzero byte down,
  // then the tail byte goes out with the last flag.
  typedef struct packed {
    logic [127:0] body;
    logic [7:0]   tail;
    verdict_t     want;
  } probe_t;

  localparam int ProbeCount = 7;
  localparam probe_t Probes [ProbeCount] = '{
    // zero byte alone, straight after reset: nothing seen, counters idle
    '{"", 8'h00, '{ClassNone, LevelNone, 5'd0, 32'd0, 32'd0, 32'd0}},
    // all-ones byte alone
    '{"", 8'hff, '{ClassNone, LevelNone, 5'd0, 32'd0, 32'd0, 32'd0}},
    // upper case folds down onto "or 1=1"
    '{"OR 1=", "1", '{ClassSql, LevelMed, 5'd10, 32'd1, 32'd0, 32'd1}},
    // script class only
    '{"Eval", "(", '{ClassXss, LevelHigh, 5'd2, 32'd1, 32'd1, 32'd2}},
    // "<script" split over two queries must not match across the boundary
    '{"<sc", "r", '{ClassNone, LevelNone, 5'd0, 32'd1, 32'd1, 32'd2}},
    '{"ip", "t", '{ClassNone, LevelNone, 5'd0, 32'd1, 32'd1, 32'd2}},
    // both classes at low severity: the tie goes to sql, total takes two
    '{"alert('a'='", "a", '{ClassSql, LevelLow, 5'd29, 32'd2, 32'd2, 32'd4}}
  };

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [111:0] m_tdata;

  injection_signature_matcher_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Signature tables, in severity order within each class.
  string sql_patterns [SqlCount] = '{
    "union select", "union all select", "; drop ", "; delete ",
    "; truncate ", "; update ", "; insert ", "into outfile",
    "into dumpfile", {"load_", "file("},
    "or 1=1", "or '1'='1", "' or '", "or true--", "or true;", "' or true",
    "sleep(", "benchmark(", "waitfor delay", "'; --", "' --", "'/*",
    "*/or/*", "char(0x", "exec(", "execute(", {"xp_", "cmdshell"},
    {"information", "_schema"},
    "' or 1", "'a'='a", "1' or '1", "admin'--"
  };

  string script_patterns [XssCount] = '{
    "<script", "javascript:", "eval(", "document.cookie", "document.write(",
    "document.location", "window.location", ".innerhtml",
    "onerror=", "onload=", "onclick=", "onmouseover=", "onfocus=",
    "onsubmit=", "<iframe", "<object", "<embed", "<svg onload", "<img src=",
    "<body onload",
    "alert(", "prompt(", "confirm(", "<marquee"
  };

  // Scanner state mirrored here: text_window[0] is the newest folded byte.
  logic [7:0]             text_window [WinLen];
  logic [SqlCount-1:0]    sql_seen;
  logic [XssCount-1:0]    xss_seen;
  logic [CounterBits-1:0] sql_tally;
  logic [CounterBits-1:0] xss_tally;
  logic [CounterBits-1:0] both_tally;

  verdict_t verdicts_due [$];
  int       sent_bytes;
  int       mismatches;
  int       stall_cycles;
  bit       hold_taken;
  bit       calm;

  assign calm = (sent_bytes >= CalmFrom) && (sent_bytes < CalmTo);

  // True when the pattern ends on the newest byte of the window.
  function automatic bit pattern_ends_here(input string pat);
    int n;
    bit ok;
    n  = pat.len();
    ok = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (text_window[n-1-k] != pat[k]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [CounterBits-1:0] bump(input logic [CounterBits-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Advance the mirrored scanner by one accepted byte; on a last byte,
  // queue the verdict it owes and clear the per-query state.
  task automatic scan_byte(input logic [7:0] raw, input logic last);
    logic [7:0] folded;
    int         sql_at;
    int         xss_at;
    logic [1:0] sql_lvl;
    logic [1:0] xss_lvl;
    verdict_t   v;
    folded = (raw >= "A" && raw <= "Z") ? raw + 8'd32 : raw;
    for (int k = WinLen - 1; k > 0; k--) text_window[k] = text_window[k-1];
    text_window[0] = folded;
    for (int i = 0; i < SqlCount; i++)
      if (pattern_ends_here(sql_patterns[i])) sql_seen[i] = 1'b1;
    for (int i = 0; i < XssCount; i++)
      if (pattern_ends_here(script_patterns[i])) xss_seen[i] = 1'b1;
    if (last) begin
      // first hit in table order is the most severe of its class
      sql_at = -1;
      xss_at = -1;
      for (int i = SqlCount - 1; i >= 0; i--) if (sql_seen[i]) sql_at = i;
      for (int i = XssCount - 1; i >= 0; i--) if (xss_seen[i]) xss_at = i;
      sql_lvl = (sql_at < 0) ? LevelNone : (sql_at < 10) ? LevelHigh :
                (sql_at < 28) ? LevelMed : LevelLow;
      xss_lvl = (xss_at < 0) ? LevelNone : (xss_at < 8) ? LevelHigh :
                (xss_at < 20) ? LevelMed : LevelLow;
      if (sql_at >= 0) begin
        sql_tally  = bump(sql_tally);
        both_tally = bump(both_tally);
      end
      if (xss_at >= 0) begin
        xss_tally  = bump(xss_tally);
        both_tally = bump(both_tally);
      end
      if (sql_at >= 0 && sql_lvl >= xss_lvl) begin
        v.threat_class    = ClassSql;
        v.threat_level    = sql_lvl;
        v.signature_index = 5'(sql_at);
      end else if (xss_at >= 0) begin
        v.threat_class    = ClassXss;
        v.threat_level    = xss_lvl;
        v.signature_index = 5'(xss_at);
      end else begin
        v.threat_class    = ClassNone;
        v.threat_level    = LevelNone;
        v.signature_index = 5'd0;
      end
      v.sql_queries_flagged = sql_tally[31:0];
      v.xss_queries_flagged = xss_tally[31:0];
      v.threats_total       = both_tally[31:0];
      verdicts_due = {verdicts_due, v};
      for (int k = 0; k < WinLen; k++) text_window[k] = 8'd0;
      sql_seen = '0;
      xss_seen = '0;
    end
  endtask

  // Offer one byte, idling first at random outside the calm range, and
  // hold it until the request is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_bytes++;
    scan_byte(b, last);
  endtask

  function automatic logic [7:0] noise_byte();
    return $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(32, 126));
  endfunction

  // Stimulus: directed probes, then random queries built around signatures.
  initial begin
    logic [7:0] query [$];
    logic [7:0] ch;
    string      sig;
    int         kind;
    int         pick;
    int         cut;
    rst        = 1'b1;
    clk        = 1'b0;
    s_tvalid   = 1'b0;
    s_tdata    = 8'd0;
    s_tlast    = 1'b0;
    sql_seen   = '0;
    xss_seen   = '0;
    sql_tally  = '0;
    xss_tally  = '0;
    both_tally = '0;
    for (int k = 0; k < WinLen; k++) text_window[k] = 8'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < ProbeCount; r++) begin
      for (int b = 15; b >= 0; b--) begin
        ch = Probes[r].body[b*8 +: 8];
        if (ch != 8'd0) send_byte(ch, 1'b0);
      end
      send_byte(Probes[r].tail, 1'b1);
      // the reset and extreme rows carry their verdict typed in; later rows
      // go through the predictor
      if (r < TypedProbes) verdicts_due[verdicts_due.size()-1] = Probes[r].want;
    end

    while (sent_bytes < RandomBytes) begin
      query.delete();
      kind = $urandom_range(99);
      if (kind < 15) begin
        // pure noise
        repeat ($urandom_range(1, 20)) query = {query, 8'($urandom_range(255))};
      end else begin
        repeat ($urandom_range(1, 3)) begin
          repeat ($urandom_range(0, 5)) query = {query, noise_byte()};
          pick = $urandom_range(SqlCount + XssCount - 1);
          sig  = (pick < SqlCount) ? sql_patterns[pick] : script_patterns[pick - SqlCount];
          // some queries carry a signature with its last character missing
          cut  = (kind < 30) ? 1 : 0;
          for (int k = 0; k < sig.len() - cut; k++) begin
            ch = sig[k];
            if (ch >= "a" && ch <= "z" && $urandom_range(1)) ch = ch - 8'd32;
            query = {query, ch};
          end
        end
        repeat ($urandom_range(0, 3)) query = {query, noise_byte()};
      end
      if (query.size() == 0) query = {query, noise_byte()};
      foreach (query[k]) send_byte(query[k], k == query.size() - 1);
    end
    s_tvalid <= 1'b0;

    // Drain outstanding verdicts, then let the pipe settle.
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: random back-pressure, one long hold-off so the block fills
  // up and stalls its input, no idling inside the calm range.
  initial begin
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!hold_taken && sent_bytes >= HoldAt) begin
        hold_taken = 1'b1;
        m_tready  <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      m_tready <= calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Check every delivered verdict against the oldest one owed.
  always @(posedge clk) begin : verdict_check
    verdict_t got;
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.threat_class        = m_tdata[1:0];
      got.threat_level        = m_tdata[3:2];
      got.signature_index     = m_tdata[8:4];
      got.sql_queries_flagged = m_tdata[40:9];
      got.xss_queries_flagged = m_tdata[72:41];
      got.threats_total       = m_tdata[104:73];
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected verdict: class %0d level %0d index %0d",
                   got.threat_class, got.threat_level, got.signature_index);
      end else begin
        want = verdicts_due.pop_front();
        if (got.threat_class !== want.threat_class ||
            got.threat_level !== want.threat_level ||
            got.signature_index !== want.signature_index ||
            got.sql_queries_flagged !== want.sql_queries_flagged ||
            got.xss_queries_flagged !== want.xss_queries_flagged ||
            got.threats_total !== want.threats_total) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("verdict mismatch at %0t: ", $realtime,
                     "want class %0d level %0d index %0d ",
                     want.threat_class, want.threat_level, want.signature_index,
                     "sql %0d xss %0d total %0d, ",
                     want.sql_queries_flagged, want.xss_queries_flagged,
                     want.threats_total,
                     "got class %0d level %0d index %0d ",
                     got.threat_class, got.threat_level, got.signature_index,
                     "sql %0d xss %0d total %0d",
                     got.sql_queries_flagged, got.xss_queries_flagged,
                     got.threats_total);
        end
      end
    end
  end

  // Watchdog: end the run if no request moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

>>> sim.f
src/ism_pkg.sv
src/ism_front.sv
src/ism_queue.sv
src/ism_back.sv
src/injection_signature_matcher_unit.sv
tb/sv/tb_injection_signature_matcher_unit.sv
